>>> rtl/egb_pkg.sv
// Shared types, constants and the control store for the extended GCD unit.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none
package egb_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int CNT_BITS   = $clog2(WORD_BITS);
    localparam int STEP_BITS  = 3;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [STEP_BITS-1:0]  t_step;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_MUL_S,
        OP_UPD_S_MUL_T,
        OP_UPD_T,
        OP_WRITE_OUT
    } t_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_IN,
        COND_CR_ZERO,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_CHECK = 3'd1;
    localparam t_step STEP_DIV   = 3'd2;
    localparam t_step STEP_OUT   = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic cr_zero;
        logic div_busy;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            3'd0:    w = '{op: OP_LOAD,        cond: COND_NO_IN,    target: STEP_IDLE};
            3'd1:    w = '{op: OP_DIV_START,   cond: COND_CR_ZERO,  target: STEP_OUT};
            3'd2:    w = '{op: OP_DIV_STEP,    cond: COND_DIV_BUSY, target: STEP_DIV};
            3'd3:    w = '{op: OP_DIV_FIX,     cond: COND_ALWAYS,   target: 3'd4};
            3'd4:    w = '{op: OP_MUL_S,       cond: COND_ALWAYS,   target: 3'd5};
            3'd5:    w = '{op: OP_UPD_S_MUL_T, cond: COND_ALWAYS,   target: 3'd6};
            3'd6:    w = '{op: OP_UPD_T,       cond: COND_ALWAYS,   target: STEP_CHECK};
            default: w = '{op: OP_WRITE_OUT,   cond: COND_OUT_BUSY, target: STEP_OUT};
        endcase
        return w;
    endfunction

    function automatic t_word to_word(input t_field v);
        return t_word'($signed(v));
    endfunction

    function automatic t_field to_field(input t_word v);
        return t_field'(v);
    endfunction

    function automatic t_word magnitude(input t_word v);
        return v[WORD_BITS-1] ? t_word'(-v) : v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/extended_gcd_bezout_unit.sv
// Extended Euclidean unit: gcd and Bezout coefficients with truncating division.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// The divider loop of WORD_BITS one-bit steps sets the cost of each iteration.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
// Depends on egb_pkg, egb_seq, egb_div and egb_dp.
`default_nettype none
module extended_gcd_bezout_unit
    import egb_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_valid,
    output logic   o_in_ready,
    input  t_field i_first_operand,
    input  t_field i_second_operand,
    output logic   o_valid,
    input  wire    i_out_ready,
    output t_field o_divisor,
    output t_field o_coef_first,
    output t_field o_coef_second
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    t_word w_num, w_den, w_quot, w_rem;
    logic  w_cr_zero, w_div_busy, w_out_busy, w_load;

    assign o_in_ready = (w_ctrl.op == OP_LOAD);
    assign w_load     = i_valid && o_in_ready;

    assign w_stat.in_valid = i_valid;
    assign w_stat.cr_zero  = w_cr_zero;
    assign w_stat.div_busy = w_div_busy;
    assign w_stat.out_busy = w_out_busy;

    egb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    egb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_busy  (w_div_busy)
    );

    egb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_load        (w_load),
        .i_first       (i_first_operand),
        .i_second      (i_second_operand),
        .i_quot        (w_quot),
        .i_rem         (w_rem),
        .i_out_ready   (i_out_ready),
        .o_num         (w_num),
        .o_den         (w_den),
        .o_cr_zero     (w_cr_zero),
        .o_out_busy    (w_out_busy),
        .o_out_valid   (o_valid),
        .o_divisor     (o_divisor),
        .o_coef_first  (o_coef_first),
        .o_coef_second (o_coef_second)
    );

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !o_in_ready)
        else $error("Sequencer stayed idle after an input beat.");

    a_write_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_in_ready)
        else $error("Result written without returning to idle.");

    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divisor == '0) |-> (o_coef_first == t_field'(1) && o_coef_second == '0))
        else $error("Zero divisor with wrong coefficients.");

endmodule
`default_nettype wire

>>> rtl/egb_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on egb_pkg for the control word layout and status struct.
`default_nettype none
module egb_seq
    import egb_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_jump;

    assign w_uw = ucode(r_step);

    always_comb begin
        case (w_uw.cond)
            COND_ALWAYS:   w_jump = 1'b1;
            COND_NO_IN:    w_jump = !i_stat.in_valid;
            COND_CR_ZERO:  w_jump = i_stat.cr_zero;
            COND_DIV_BUSY: w_jump = i_stat.div_busy;
            COND_OUT_BUSY: w_jump = i_stat.out_busy;
            default:       w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_uw.target : t_step'(r_step + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op = w_uw.op;

endmodule
`default_nettype wire

>>> rtl/egb_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on egb_pkg for the word type and control codes.
`default_nettype none
module egb_div
    import egb_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_word i_num,
    input  t_word i_den,
    output t_word o_quot,
    output t_word o_rem,
    output logic  o_busy
);

    t_word                 r_rm;
    t_word                 r_qm;
    t_word                 r_dm;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_nneg;
    logic                  r_dneg;
    logic [WORD_BITS:0]    w_shift;
    logic [WORD_BITS:0]    w_trial;

    assign w_shift = {r_rm, r_qm[WORD_BITS-1]};
    assign w_trial = w_shift - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.op == OP_DIV_START) begin
            r_cnt <= CNT_BITS'(WORD_BITS - 1);
        end else if (i_ctrl.op == OP_DIV_STEP) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_DIV_START) begin
            r_rm   <= '0;
            r_qm   <= magnitude(i_num);
            r_dm   <= magnitude(i_den);
            r_nneg <= i_num[WORD_BITS-1];
            r_dneg <= i_den[WORD_BITS-1];
        end else if (i_ctrl.op == OP_DIV_STEP) begin
            r_rm <= w_trial[WORD_BITS] ? w_shift[WORD_BITS-1:0] : w_trial[WORD_BITS-1:0];
            r_qm <= {r_qm[WORD_BITS-2:0], !w_trial[WORD_BITS]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = (r_nneg != r_dneg) ? t_word'(-r_qm) : r_qm;
    assign o_rem  = r_nneg ? t_word'(-r_rm) : r_rm;

endmodule
`default_nettype wire

>>> rtl/egb_dp.sv
// Datapath: remainder and coefficient registers, the multiplier and the result register.
// Depends on egb_pkg; takes quotient and remainder from egb_div.
`default_nettype none
module egb_dp
    import egb_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_ctrl  i_ctrl,
    input  wire    i_load,
    input  t_field i_first,
    input  t_field i_second,
    input  t_word  i_quot,
    input  t_word  i_rem,
    input  wire    i_out_ready,
    output t_word  o_num,
    output t_word  o_den,
    output logic   o_cr_zero,
    output logic   o_out_busy,
    output logic   o_out_valid,
    output t_field o_divisor,
    output t_field o_coef_first,
    output t_field o_coef_second
);

    t_word r_pr, r_cr, r_ps, r_cs, r_pt, r_ct;
    t_word r_q, r_rem, r_prod;
    t_word w_mul_b;
    logic  r_out_valid;
    logic  w_write;

    assign o_out_busy = r_out_valid && !i_out_ready;
    assign w_write    = (i_ctrl.op == OP_WRITE_OUT) && !o_out_busy;
    assign w_mul_b    = (i_ctrl.op == OP_MUL_S) ? r_cs : r_ct;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pr <= to_word(i_first);
            r_cr <= to_word(i_second);
            r_ps <= t_word'(1);
            r_cs <= '0;
            r_pt <= '0;
            r_ct <= t_word'(1);
        end
        case (i_ctrl.op)
            OP_DIV_FIX: begin
                r_q   <= i_quot;
                r_rem <= i_rem;
            end
            OP_MUL_S: begin
                r_prod <= r_q * w_mul_b;
            end
            OP_UPD_S_MUL_T: begin
                r_ps   <= r_cs;
                r_cs   <= r_ps - r_prod;
                r_prod <= r_q * w_mul_b;
            end
            OP_UPD_T: begin
                r_pt <= r_ct;
                r_ct <= r_pt - r_prod;
                r_pr <= r_cr;
                r_cr <= r_rem;
            end
            default: begin
            end
        endcase
        if (w_write) begin
            o_divisor     <= to_field(r_pr);
            o_coef_first  <= to_field(r_ps);
            o_coef_second <= to_field(r_pt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_num       = r_pr;
    assign o_den       = r_cr;
    assign o_cr_zero   = (r_cr == '0);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire
